// ===== src/population_std_deviation_macros.svh =====
// Assertion macros for the population_std_deviation RTL
`ifndef POPULATION_STD_DEVIATION_MACROS_SVH
`define POPULATION_STD_DEVIATION_MACROS_SVH
`ifndef SYNTH
`define PSD_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("psd assertion failed");
`define PSD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psd assertion failed");
`else
`define PSD_ASSERT(lbl, expr)
`define PSD_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== src/psd_pkg.sv =====
`timescale 1ns / 1ps
package psd_pkg;
   localparam int DATA_W    = 32;
   localparam int STD_W     = 32;
   localparam int CNT_OUT_W = 7;

   typedef struct packed {
      logic [STD_W-1:0]     std_dev;
      logic [CNT_OUT_W-1:0] sample_count;
      logic                 overflowed;
   } psd_result_type;
endpackage

// ===== src/psd_fifo.sv =====
`timescale 1ns / 1ps
module psd_fifo #(
   parameter int W = 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data,
   output logic [1:0]   count
);
   logic [W-1:0] mem_ff [0:1];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign count     = cnt_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end
endmodule

// ===== src/psd_front.sv =====
`timescale 1ns / 1ps
module psd_front #(
   parameter int MAX_SAMPLES = 64,
   parameter int AW = 6,
   parameter int CW = 7,
   parameter int SW = 39
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [psd_pkg::DATA_W-1:0]  req_sample,
   input  logic                        req_last_sample,
   output logic                        job_valid,
   input  logic                        job_ready,
   output logic [SW+CW+1:0]            job_data,
   input  logic                        release_bank,
   input  logic [AW:0]                 rd_addr,
   output logic [psd_pkg::DATA_W-1:0]  rd_data
);
   import psd_pkg::*;

   logic [DATA_W-1:0] mem [0:(2**(AW+1))-1];
   logic [DATA_W-1:0] rd_data_ff;
   logic [CW-1:0]     cnt_ff, cnt_in, cnt_nx;
   logic [SW-1:0]     sum_ff, sum_in, sum_nx;
   logic              drop_ff, drop_in, drop_nx;
   logic              bank_ff, bank_in;
   logic [1:0]        jobs_ff, jobs_in;
   logic              accept, full, push;

   assign req_ready = (jobs_ff != 2'd2) && job_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (cnt_ff == CW'(MAX_SAMPLES));
   assign push      = accept && req_last_sample;
   assign job_valid = push;
   assign job_data  = {sum_nx, cnt_nx, drop_nx, bank_ff};
   assign rd_data   = rd_data_ff;

   always_comb begin
      cnt_nx  = full ? cnt_ff : CW'(cnt_ff + 1'b1);
      sum_nx  = full ? sum_ff
                     : SW'(sum_ff + {{(SW-DATA_W){req_sample[DATA_W-1]}}, req_sample});
      drop_nx = drop_ff | full;
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      drop_in = drop_ff;
      bank_in = bank_ff;
      if (accept) begin
         if (req_last_sample) begin
            cnt_in  = '0;
            sum_in  = '0;
            drop_in = 1'b0;
            bank_in = ~bank_ff;
         end else begin
            cnt_in  = cnt_nx;
            sum_in  = sum_nx;
            drop_in = drop_nx;
         end
      end
      jobs_in = 2'(jobs_ff + {1'b0, push} - {1'b0, release_bank});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         sum_ff  <= '0;
         drop_ff <= 1'b0;
         bank_ff <= 1'b0;
         jobs_ff <= 2'd0;
      end else begin
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         drop_ff <= drop_in;
         bank_ff <= bank_in;
         jobs_ff <= jobs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !full) begin
         mem[{bank_ff, cnt_ff[AW-1:0]}] <= req_sample;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule

// ===== src/psd_div.sv =====
`timescale 1ns / 1ps
module psd_div #(
   parameter int DW = 71,
   parameter int NW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [NW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quot,
   output logic [NW-1:0] rem
);
   localparam int KW = $clog2(DW + 1);

   logic [DW-1:0] q_ff;
   logic [NW-1:0] r_ff, d_ff;
   logic [KW-1:0] cnt_ff;
   logic          run_ff, done_ff;
   logic [NW:0]   shifted, diff;
   logic          ge;

   assign shifted = {r_ff, q_ff[DW-1]};
   assign ge      = (shifted >= {1'b0, d_ff});
   assign diff    = shifted - {1'b0, d_ff};
   assign done    = done_ff;
   assign quot    = q_ff;
   assign rem     = r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= KW'(DW);
         end else if (run_ff) begin
            cnt_ff <= KW'(cnt_ff - 1'b1);
            if (cnt_ff == KW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (run_ff) begin
         r_ff <= ge ? diff[NW-1:0] : shifted[NW-1:0];
         q_ff <= {q_ff[DW-2:0], ge};
      end
   end
endmodule

// ===== src/psd_back.sv =====
`timescale 1ns / 1ps
module psd_back #(
   parameter int AW = 6,
   parameter int CW = 7,
   parameter int SW = 39,
   parameter int DW = 71
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   output logic                        job_ready,
   input  logic [SW+CW+1:0]            job_data,
   output logic                        release_bank,
   output logic [AW:0]                 rd_addr,
   input  logic [psd_pkg::DATA_W-1:0]  rd_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output psd_pkg::psd_result_type     rsp_result
);
   import psd_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MEAN = 3'd1;
   localparam logic [2:0] ST_PASS = 3'd2;
   localparam logic [2:0] ST_VAR  = 3'd3;
   localparam logic [2:0] ST_SQRT = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]     state_ff, state_in;
   logic           neg_ff, drop_ff, bank_ff;
   logic [CW-1:0]  n_ff, idx_ff;
   logic [32:0]    mean_ff;
   logic           p0_ff, p1_ff, p2_ff;
   logic [31:0]    m_ff;
   logic [63:0]    sq_ff;
   logic [DW-1:0]  acc_ff;
   logic [63:0]    v_ff, res_ff, bit_ff;
   logic           out_valid_ff, out_valid_in;
   psd_result_type out_ff;

   logic [SW-1:0]  j_sum, j_mag;
   logic [CW-1:0]  j_n;
   logic           j_drop, j_bank, pop, issue, pass_end, load_out;
   logic           div_start, div_done;
   logic [DW-1:0]  div_num, div_quot;
   logic [CW-1:0]  div_den, div_rem;
   logic [33:0]    qs, mean34, diff, mag;
   logic [63:0]    trial;

   assign {j_sum, j_n, j_drop, j_bank} = job_data;
   assign j_mag     = j_sum[SW-1] ? SW'(~j_sum + 1'b1) : j_sum;
   assign job_ready = (state_ff == ST_IDLE);
   assign pop       = job_valid && job_ready;
   assign issue     = (state_ff == ST_PASS) && (idx_ff != n_ff);
   assign pass_end  = (state_ff == ST_PASS) && (idx_ff == n_ff) && !p0_ff && !p1_ff && !p2_ff;
   assign release_bank = pass_end;
   assign rd_addr   = {bank_ff, idx_ff[AW-1:0]};
   assign load_out  = (state_ff == ST_DONE) && (!out_valid_ff || rsp_ready);
   assign div_start = pop || pass_end;
   assign div_num   = (state_ff == ST_IDLE) ? {{(DW-SW){1'b0}}, j_mag} : acc_ff;
   assign div_den   = (state_ff == ST_IDLE) ? j_n : n_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   psd_div #(.DW(DW), .NW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      qs     = {1'b0, div_quot[32:0]};
      mean34 = neg_ff ? 34'(-qs - {33'd0, (div_rem != '0)}) : qs;
      diff   = 34'({{2{rd_data[31]}}, rd_data} - {mean_ff[32], mean_ff});
      mag    = diff[33] ? 34'(-diff) : diff;
      trial  = res_ff + bit_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (pop) state_in = ST_MEAN;
         ST_MEAN: if (div_done) state_in = ST_PASS;
         ST_PASS: if (pass_end) state_in = ST_VAR;
         ST_VAR:  if (div_done) state_in = ST_SQRT;
         ST_SQRT: if (bit_ff == 64'd0) state_in = ST_DONE;
         ST_DONE: if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      out_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         p0_ff        <= 1'b0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         p0_ff        <= issue;
         p1_ff        <= p0_ff;
         p2_ff        <= p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         neg_ff  <= j_sum[SW-1];
         n_ff    <= j_n;
         drop_ff <= j_drop;
         bank_ff <= j_bank;
         acc_ff  <= '0;
      end
      if ((state_ff == ST_MEAN) && div_done) begin
         mean_ff <= mean34[32:0];
         idx_ff  <= '0;
      end
      if (issue) begin
         idx_ff <= CW'(idx_ff + 1'b1);
      end
      if (p0_ff) begin
         m_ff <= mag[31:0];
      end
      if (p1_ff) begin
         sq_ff <= m_ff * m_ff;
      end
      if (p2_ff) begin
         acc_ff <= DW'(acc_ff + {{(DW-64){1'b0}}, sq_ff});
      end
      if ((state_ff == ST_VAR) && div_done) begin
         v_ff   <= div_quot[63:0];
         res_ff <= 64'd0;
         bit_ff <= 64'd1 << 62;
      end
      if ((state_ff == ST_SQRT) && (bit_ff != 64'd0)) begin
         if (v_ff >= trial) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (load_out) begin
         out_ff.std_dev      <= res_ff[31:0];
         out_ff.sample_count <= CNT_OUT_W'(n_ff);
         out_ff.overflowed   <= drop_ff;
      end
   end
endmodule

// ===== src/population_std_deviation.sv =====
// Population standard deviation over a set of signed Q16.16 samples. Each accepted item is
// stored in the sample memory unless the set is already full; the item marked last closes
// the set, and one result (floored std_dev in unsigned Q16.16, count of kept samples that
// saturates at MAX_SAMPLES, overflow flag) follows. Up to MAX_SAMPLES samples are kept per
// set; further ones are dropped and flagged. The sample memory has two halves, so the next
// set loads while the previous one is computed; intake stalls only when two finished sets
// still hold both halves. After its last item, a set goes through the bit-serial divider
// (used once for the mean, once for the variance), one memory read per sample in the
// deviation pass, and a 32-step square root.
`timescale 1ns / 1ps
`include "population_std_deviation_macros.svh"
module population_std_deviation #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [psd_pkg::DATA_W-1:0]  req_sample,
   input  logic                               req_last_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [psd_pkg::STD_W-1:0]          rsp_std_dev,
   output logic [psd_pkg::CNT_OUT_W-1:0]      rsp_sample_count,
   output logic                               rsp_overflowed
);
   import psd_pkg::*;

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int SW = DATA_W + CW;
   localparam int DW = 2 * DATA_W + CW;
   localparam int JW = SW + CW + 2;

   logic              job_push, fifo_ready, job_valid, job_pop;
   logic [JW-1:0]     job_in, job_out;
   logic [1:0]        fifo_count;
   logic              release_bank;
   logic [AW:0]       rd_addr;
   logic [DATA_W-1:0] rd_data;
   psd_result_type    result;

   psd_front #(.MAX_SAMPLES(MAX_SAMPLES), .AW(AW), .CW(CW), .SW(SW)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .job_valid       (job_push),
      .job_ready       (fifo_ready),
      .job_data        (job_in),
      .release_bank    (release_bank),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   psd_fifo #(.W(JW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (job_push),
      .in_ready  (fifo_ready),
      .in_data   (job_in),
      .out_valid (job_valid),
      .out_ready (job_pop),
      .out_data  (job_out),
      .count     (fifo_count)
   );

   psd_back #(.AW(AW), .CW(CW), .SW(SW), .DW(DW)) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_ready    (job_pop),
      .job_data     (job_out),
      .release_bank (release_bank),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_result   (result)
   );

   assign rsp_std_dev      = result.std_dev;
   assign rsp_sample_count = result.sample_count;
   assign rsp_overflowed   = result.overflowed;

   `PSD_ASSERT(a_no_push_when_full, !(job_push && !fifo_ready))
   `PSD_ASSERT_IMP(a_stall_on_two_sets, fifo_count == 2'd2, !req_ready)
   `PSD_ASSERT_IMP(a_release_not_while_idle, release_bank, !job_pop)
endmodule
